[rtl/text_console_cell_engine_unit_macros.svh]
// Assertion macros shared by the checker of the console cell engine.
// No dependencies.
`ifndef TEXT_CONSOLE_CELL_ENGINE_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CELL_ENGINE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TCE_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define TCE_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

[rtl/tce_pkg.sv]
// Shared types and constants of the console cell engine.
// No dependencies.
package tce_pkg;
    typedef enum logic [1:0] {
        ACT_PRINT = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_NUL       = 8'd0;

    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    // Result fields of one item.
    typedef struct packed {
        logic [13:0] cursor_offset;
        logic [6:0]  cursor_col;
        logic [5:0]  cursor_line;
        logic        scrolled;
        logic [7:0]  cell_char;
        logic [7:0]  cell_color;
        logic        bad_request;
    } t_result;
endpackage

[rtl/tce_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/text_console_cell_engine_unit.sv]
// Top level of the console cell engine: sequencer, cursor state and cell store.
// Depends on tce_pkg and tce_ram.
//
//  channel  direction  handshake        payload
//  in       input      i_valid/o_stall  action, char_code, attribute, position
//  out      output     o_valid/i_stall  cursor and cell fields
//  cfg      input      i_cfg_valid/o_cfg_ready  index, data
//
// Reset starts a pass that zeroes the store, one cell per cycle (MAX_COLUMNS*MAX_LINES).
// Items end in S_DONE, which registers the result: a plain character, tab or backspace
// passes S_PLAIN and S_ADV, return or backspace at column 0 S_ADV, a read S_RD_WAIT,
// a set S_SET, a bad request none. Newline fills to the line end, scroll shifts rows up
// and blanks freed ones, clear blanks the store. Input stalls while an item is at work,
// a result waits or a register write is offered; the next item follows the taken result.
module text_console_cell_engine_unit #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_LINES   = 64,
    parameter int SCROLL_STEP = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_attribute,
    input  logic [13:0] i_position,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [13:0] o_cursor_offset,
    output logic [6:0]  o_cursor_col,
    output logic [5:0]  o_cursor_line,
    output logic        o_scrolled,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_color,
    output logic        o_bad_request,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import tce_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_LINES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_LINES + 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_PLAIN, S_NL_RD, S_NL_WR, S_ADV, S_SC_RD, S_SC_WR,
        S_SC_FILL, S_CLEAR, S_SET, S_RD_WAIT, S_DONE
    } t_state;

    t_state      r_state;
    logic [7:0]  r_columns;
    logic [6:0]  r_rows;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [AW:0]   r_addr;
    logic [CW-1:0] r_i;
    logic [7:0]  r_ch;
    logic [7:0]  r_attr;
    logic [1:0]  r_act;
    logic        r_bs;
    logic        r_scr;
    logic        r_bad;
    logic        r_ovalid;
    t_result     r_res;
    logic [13:0] r_cell;
    logic [13:0] r_quot;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata, rdata;

    tce_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // Effective screen size after range limiting of the registers.
    logic [CW-1:0] nc;
    logic [RW-1:0] nr;
    logic [13:0]   cells;
    always_comb begin
        if (r_columns == 8'd0) nc = CW'(1);
        else if (32'(r_columns) > MAX_COLUMNS) nc = CW'(MAX_COLUMNS);
        else nc = CW'(r_columns);
        if (32'(r_rows) < SCROLL_STEP + 1) nr = RW'(SCROLL_STEP + 1);
        else if (32'(r_rows) > MAX_LINES) nr = RW'(MAX_LINES);
        else nr = RW'(r_rows);
        cells = 14'(32'(nc) * 32'(nr));
    end

    logic [AW:0] cur_idx;
    assign cur_idx = (AW+1)'(32'(r_row) * 32'(nc) + 32'(r_col));

    // A register write takes precedence over an item in the same cycle.
    logic accept;
    assign o_stall     = (r_state != S_IDLE) || r_ovalid || i_cfg_valid;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_ovalid;

    // Store port steering for each state.
    always_comb begin
        we    = 1'b0;
        waddr = r_addr[AW-1:0];
        wdata = {CH_SPACE, r_attr};
        raddr = r_addr[AW-1:0];
        unique case (r_state)
            S_INIT:    begin we = 1'b1; wdata = 16'd0; end
            S_CLEAR:   begin we = 1'b1; wdata = {CH_SPACE, 8'd0}; end
            S_PLAIN:   begin
                we = (r_col < nc) && (r_row < nr);
                waddr = cur_idx[AW-1:0];
                wdata = {r_ch, r_attr};
            end
            S_NL_WR:   we = (rdata[15:8] == CH_NUL);
            S_SC_WR:   begin
                we = 1'b1;
                waddr = AW'(r_addr - (AW+1)'(32'(SCROLL_STEP) * 32'(nc)));
                wdata = rdata;
            end
            S_SC_FILL: we = 1'b1;
            default:   ;
        endcase
    end

    // Sequencer, cursor state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_addr    <= '0;
            r_columns <= 8'd80;
            r_rows    <= 7'd25;
            r_col     <= '0;
            r_row     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_COLUMNS) r_columns <= i_cfg_data;
                else r_rows <= i_cfg_data[6:0];
                r_col <= '0;
                r_row <= '0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_addr <= r_addr + 1'b1;
                    if (32'(r_addr) == DEPTH - 1) r_state <= S_IDLE;
                end
                S_IDLE: if (accept) begin
                    // Tab and backspace both write a space.
                    r_ch <= (i_char_code == CH_TAB || i_char_code == CH_BACKSPACE)
                            ? CH_SPACE : i_char_code;
                    r_attr <= i_attribute;
                    r_act <= i_action;
                    r_bs <= (i_action == ACT_PRINT) && (i_char_code == CH_BACKSPACE);
                    r_scr <= 1'b0; r_bad <= 1'b0;
                    r_cell <= {1'b0, i_position[13:1]};
                    r_quot <= '0;
                    unique case (t_action'(i_action))
                        ACT_PRINT: begin
                            if (i_char_code == CH_NEWLINE) begin
                                r_addr <= cur_idx; r_i <= r_col; r_state <= S_NL_RD;
                            end else if (i_char_code == CH_RETURN) begin
                                r_col <= '0; r_state <= S_ADV;
                            end else if (i_char_code == CH_BACKSPACE) begin
                                if (r_col != '0) begin
                                    r_col <= r_col - 1'b1;
                                    r_state <= S_PLAIN;
                                end else r_state <= S_ADV;
                            end else r_state <= S_PLAIN;
                        end
                        ACT_SET: begin
                            if ({1'b0, i_position[13:1]} >= cells) begin
                                r_bad <= 1'b1; r_state <= S_DONE;
                            end else r_state <= S_SET;
                        end
                        ACT_CLEAR: begin
                            r_addr <= '0; r_col <= '0; r_row <= '0; r_state <= S_CLEAR;
                        end
                        default: begin
                            if (i_position >= cells || 32'(i_position) >= DEPTH) begin
                                r_bad <= 1'b1; r_state <= S_DONE;
                            end else begin
                                r_addr <= (AW+1)'(i_position); r_state <= S_RD_WAIT;
                            end
                        end
                    endcase
                end
                S_PLAIN: begin
                    // Backspace already stepped back; others step forward.
                    r_col <= r_bs ? r_col : r_col + 1'b1;
                    r_state <= S_ADV;
                end
                S_NL_RD: begin
                    if (r_i >= nc) begin
                        r_col <= '0; r_row <= r_row + 1'b1; r_state <= S_ADV;
                    end else r_state <= S_NL_WR;
                end
                S_NL_WR: begin
                    r_i <= r_i + 1'b1; r_addr <= r_addr + 1'b1; r_state <= S_NL_RD;
                end
                S_ADV: begin
                    if (r_col >= nc) begin
                        r_col <= '0;
                        if (r_row + 1'b1 >= nr) begin
                            r_addr <= (AW+1)'(32'(SCROLL_STEP) * 32'(nc));
                            r_state <= S_SC_RD; r_scr <= 1'b1;
                        end else begin
                            r_row <= r_row + 1'b1; r_state <= S_DONE;
                        end
                    end else if (r_row >= nr) begin
                        r_addr <= (AW+1)'(32'(SCROLL_STEP) * 32'(nc));
                        r_state <= S_SC_RD; r_scr <= 1'b1;
                    end else r_state <= S_DONE;
                end
                S_SC_RD: begin
                    if (r_addr >= (AW+1)'(32'(nr) * 32'(nc))) begin
                        r_addr <= (AW+1)'((32'(nr) - SCROLL_STEP) * 32'(nc));
                        r_state <= S_SC_FILL;
                    end else r_state <= S_SC_WR;
                end
                S_SC_WR: begin
                    r_addr <= r_addr + 1'b1; r_state <= S_SC_RD;
                end
                S_SC_FILL: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr + 1'b1 >= (AW+1)'(32'(nr) * 32'(nc))) begin
                        r_row <= RW'(32'(nr) - SCROLL_STEP); r_state <= S_DONE;
                    end
                end
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (32'(r_addr) == DEPTH - 1) r_state <= S_DONE;
                end
                S_SET: begin
                    // Divide by the column count one subtraction of a row a cycle.
                    if (r_cell >= 14'(nc)) begin
                        r_cell <= r_cell - 14'(nc); r_quot <= r_quot + 1'b1;
                    end else begin
                        r_row <= RW'(r_quot); r_col <= CW'(r_cell); r_state <= S_DONE;
                    end
                end
                S_RD_WAIT: r_state <= S_DONE;
                S_DONE: begin
                    r_res.cursor_offset <= 14'(cur_idx << 1);
                    r_res.cursor_col    <= 7'(r_col);
                    r_res.cursor_line   <= 6'(r_row);
                    r_res.scrolled      <= r_scr;
                    r_res.bad_request   <= r_bad;
                    r_res.cell_char     <= (r_act == ACT_READ && !r_bad) ? rdata[15:8] : 8'd0;
                    r_res.cell_color    <= (r_act == ACT_READ && !r_bad) ? rdata[7:0] : 8'd0;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_cursor_offset = r_res.cursor_offset;
    assign o_cursor_col    = r_res.cursor_col;
    assign o_cursor_line   = r_res.cursor_line;
    assign o_scrolled      = r_res.scrolled;
    assign o_cell_char     = r_res.cell_char;
    assign o_cell_color    = r_res.cell_color;
    assign o_bad_request   = r_res.bad_request;
endmodule

[rtl/tce_checker.sv]
// Port-level checker of the console cell engine, bound to the top level.
// Depends on the assertion macro header.
`include "text_console_cell_engine_unit_macros.svh"
module tce_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_cfg_ready,
    input logic        o_scrolled,
    input logic        o_bad_request,
    input logic [7:0]  o_cell_char
);
    // An accepted item blocks further input once it is registered.
    `TCE_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "item overlap")
    // A waiting result holds off input.
    `TCE_ASSERT_IMPL(a_out_blocks, i_clk, i_rst_n, o_valid, o_stall && !o_cfg_ready, "stall")
    // A held result stays valid.
    `TCE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped")
    // A bad request never reads a character.
    `TCE_ASSERT_IMPL(a_bad, i_clk, i_rst_n, o_valid && o_bad_request,
        o_cell_char == 8'd0 && !o_scrolled, "bad request data")
endmodule

bind text_console_cell_engine_unit tce_checker u_tce_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for text_console_cell_engine_unit.
// Depends on tce_pkg and the RTL of the block. It predicts every result with its own model
// of the cell store and cursor, and drives both channels with random gaps and stalls.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tce_pkg::*;

    localparam int COLS_MAX     = 128;
    localparam int LINES_MAX    = 64;
    localparam int SCROLL_LINES = 5;
    localparam int STORE_CELLS  = COLS_MAX * LINES_MAX;
    localparam int CYCLE_LIMIT  = 6000000;

    // Console model: cell store, cursor and screen size, plus the queue of
    // results still owed by the block.
    class console_scoreboard;
        logic [7:0] cell_chr [STORE_CELLS];
        logic [7:0] cell_clr [STORE_CELLS];
        int         cur_col;
        int         cur_row;
        int         columns_reg;
        int         rows_reg;
        t_result    owed_results[$];
        int         mismatches;

        function new();
            for (int k = 0; k < STORE_CELLS; k++) begin
                cell_chr[k] = CH_NUL;
                cell_clr[k] = 8'h00;
            end
            cur_col = 0;
            cur_row = 0;
            columns_reg = 80;
            rows_reg = 25;
            mismatches = 0;
        endfunction

        function int eff_cols();
            if (columns_reg == 0) return 1;
            if (columns_reg > COLS_MAX) return COLS_MAX;
            return columns_reg;
        endfunction

        function int eff_rows();
            if (rows_reg < SCROLL_LINES + 1) return SCROLL_LINES + 1;
            if (rows_reg > LINES_MAX) return LINES_MAX;
            return rows_reg;
        endfunction

        function void write_register(logic idx, logic [7:0] data);
            if (idx == REG_COLUMNS) columns_reg = data;
            else rows_reg = data & 8'h7f;
            cur_col = 0;
            cur_row = 0;
        endfunction

        function void put_cell(int c, int r, logic [7:0] ch, logic [7:0] clr);
            int idx;
            idx = r * eff_cols() + c;
            if (c >= eff_cols() || r >= eff_rows() || idx >= STORE_CELLS) return;
            cell_chr[idx] = ch;
            cell_clr[idx] = clr;
        endfunction

        // Prints one byte and returns 1 when the screen scrolled.
        function bit print_byte(logic [7:0] ch, logic [7:0] clr);
            int nc;
            int nr;
            nc = eff_cols();
            nr = eff_rows();
            if (ch == CH_NEWLINE) begin
                for (int c = cur_col; c < nc; c++)
                    if (cell_chr[cur_row * nc + c] == CH_NUL)
                        put_cell(c, cur_row, CH_SPACE, clr);
                cur_col = 0;
                cur_row++;
            end else if (ch == CH_RETURN) begin
                cur_col = 0;
            end else if (ch == CH_TAB) begin
                put_cell(cur_col, cur_row, CH_SPACE, clr);
                cur_col++;
            end else if (ch == CH_BACKSPACE) begin
                if (cur_col > 0) begin
                    cur_col--;
                    put_cell(cur_col, cur_row, CH_SPACE, clr);
                end
            end else begin
                put_cell(cur_col, cur_row, ch, clr);
                cur_col++;
            end
            if (cur_col >= nc) begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row < nr) return 0;
            // Shift the screen up and blank the freed rows.
            for (int r = 0; r < nr - SCROLL_LINES; r++)
                for (int c = 0; c < nc; c++) begin
                    cell_chr[r * nc + c] = cell_chr[(r + SCROLL_LINES) * nc + c];
                    cell_clr[r * nc + c] = cell_clr[(r + SCROLL_LINES) * nc + c];
                end
            for (int r = nr - SCROLL_LINES; r < nr; r++)
                for (int c = 0; c < nc; c++)
                    put_cell(c, r, CH_SPACE, clr);
            cur_row = nr - SCROLL_LINES;
            return 1;
        endfunction

        function void note_item(t_action act, logic [7:0] ch, logic [7:0] clr,
                                logic [13:0] pos);
            t_result res;
            int      cells;
            cells = eff_cols() * eff_rows();
            res = '0;
            case (act)
                ACT_PRINT: res.scrolled = print_byte(ch, clr);
                ACT_SET: begin
                    if (pos / 2 >= cells) res.bad_request = 1'b1;
                    else begin
                        cur_row = (pos / 2) / eff_cols();
                        cur_col = (pos / 2) % eff_cols();
                    end
                end
                ACT_CLEAR: begin
                    for (int k = 0; k < STORE_CELLS; k++) begin
                        cell_chr[k] = CH_SPACE;
                        cell_clr[k] = 8'h00;
                    end
                    cur_col = 0;
                    cur_row = 0;
                end
                default: begin
                    if (pos >= cells) res.bad_request = 1'b1;
                    else begin
                        res.cell_char  = cell_chr[pos];
                        res.cell_color = cell_clr[pos];
                    end
                end
            endcase
            res.cursor_offset = 14'((cur_row * eff_cols() + cur_col) * 2);
            res.cursor_col    = 7'(cur_col);
            res.cursor_line   = 6'(cur_row);
            owed_results.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
                return;
            end
            want = owed_results.pop_front();
            if (got.cursor_offset !== want.cursor_offset || got.cursor_col !== want.cursor_col
                || got.cursor_line !== want.cursor_line || got.scrolled !== want.scrolled
                || got.cell_char !== want.cell_char || got.cell_color !== want.cell_color
                || got.bad_request !== want.bad_request) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: expected off=%0d col=%0d line=%0d scr=%0b chr=%h clr=%h bad=%0b",
                             want.cursor_offset, want.cursor_col, want.cursor_line,
                             want.scrolled, want.cell_char, want.cell_color,
                             want.bad_request);
                    $display("       got      off=%0d col=%0d line=%0d scr=%0b chr=%h clr=%h bad=%0b",
                             got.cursor_offset, got.cursor_col, got.cursor_line,
                             got.scrolled, got.cell_char, got.cell_color,
                             got.bad_request);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_action;
    logic [7:0]  i_char_code;
    logic [7:0]  i_attribute;
    logic [13:0] i_position;
    logic        o_valid;
    logic        i_stall;
    t_result     out_fields;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;

    console_scoreboard console = new();
    int  items_sent;
    int  burst_left;
    int  cycle_count;
    logic hold_off;

    text_console_cell_engine_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_char_code(i_char_code),
        .i_attribute(i_attribute), .i_position(i_position),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_cursor_offset(out_fields.cursor_offset), .o_cursor_col(out_fields.cursor_col),
        .o_cursor_line(out_fields.cursor_line), .o_scrolled(out_fields.scrolled),
        .o_cell_char(out_fields.cell_char), .o_cell_color(out_fields.cell_color),
        .o_bad_request(out_fields.bad_request),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("text_console_cell_engine_unit regression: fail");
            $finish;
        end
    end

    // Result monitor.
    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall) console.check_result(out_fields);

    // Receiver stall pattern: stretches of no stall, light and heavy stalling,
    // plus the long hold-off.
    initial begin
        int mode;
        int span;
        i_stall = 1'b0;
        mode = 0;
        span = 0;
        forever begin
            @(negedge i_clk);
            if (span == 0) begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(10, 150);
            end
            span--;
            i_stall = hold_off || (mode == 1 && $urandom_range(0, 99) < 30)
                      || (mode == 2 && $urandom_range(0, 99) < 75);
        end
    end

    // Long hold-off while the sender keeps offering items.
    initial begin
        hold_off = 1'b0;
        wait (items_sent >= 40);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(negedge i_clk);
        hold_off = 1'b0;
    end

    // Offers one item, called at a falling edge; returns at a falling edge.
    task automatic send_item(t_action act, logic [7:0] ch, logic [7:0] clr,
                             logic [13:0] pos);
        i_valid = 1'b1;
        i_action = act;
        i_char_code = ch;
        i_attribute = clr;
        i_position = pos;
        do @(posedge i_clk); while (o_stall);
        console.note_item(act, ch, clr, pos);
        items_sent++;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) begin
                i_valid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Waits for the block to go idle, then writes one register.
    task automatic write_reg(logic idx, logic [7:0] data);
        i_valid = 1'b0;
        while (console.owed_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        console.write_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // One random item, weighted toward printing and reading on screen.
    task automatic send_random();
        int          pick;
        int          cells;
        logic [7:0]  ch;
        logic [13:0] pos;
        cells = console.eff_cols() * console.eff_rows();
        ch = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: ch = CH_NEWLINE;
            1: ch = CH_RETURN;
            2: ch = CH_TAB;
            3: ch = CH_BACKSPACE;
            default: ;
        endcase
        pos = ($urandom_range(0, 6) == 0) ? 14'($urandom_range(0, 16383))
                                          : 14'($urandom_range(0, 2 * cells + 3));
        pick = $urandom_range(0, 99);
        if (pick < 60) send_item(ACT_PRINT, ch, 8'($urandom_range(0, 255)), pos);
        else if (pick < 75) send_item(ACT_SET, ch, 8'($urandom_range(0, 255)), pos);
        else if (pick < 77) send_item(ACT_CLEAR, ch, 8'($urandom_range(0, 255)), pos);
        else send_item(ACT_READ, ch, 8'($urandom_range(0, 255)),
                       ($urandom_range(0, 1) == 0) ? 14'(pos / 2) : pos);
    endtask

    logic [7:0] col_settings [8] = '{8'd80, 8'd0, 8'd255, 8'd8, 8'd128, 8'd1, 8'd16, 8'd40};
    logic [7:0] row_settings [8] = '{8'd25, 8'd0, 8'd127, 8'd6, 8'd64, 8'd200, 8'd10, 8'd6};
    int         phase_items  [8] = '{110, 110, 40, 130, 40, 130, 130, 110};

    initial begin
        cycle_count = 0;
        items_sent = 0;
        burst_left = 5;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_action = ACT_PRINT;
        i_char_code = 8'h00;
        i_attribute = 8'h00;
        i_position = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_COLUMNS;
        i_cfg_data = 8'h00;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed items on the default 80 by 25 screen.
        send_item(ACT_READ, 8'h00, 8'h00, 14'd0);
        send_item(ACT_PRINT, 8'h41, 8'h1f, 14'd0);
        send_item(ACT_PRINT, CH_NEWLINE, 8'h2e, 14'd0);
        send_item(ACT_READ, 8'h00, 8'h00, 14'd1);
        send_item(ACT_READ, 8'h00, 8'h00, 14'd79);
        send_item(ACT_PRINT, CH_BACKSPACE, 8'h33, 14'd0);
        send_item(ACT_PRINT, CH_TAB, 8'h44, 14'd0);
        send_item(ACT_PRINT, 8'hff, 8'hff, 14'd0);
        send_item(ACT_PRINT, CH_BACKSPACE, 8'h55, 14'd0);
        send_item(ACT_PRINT, 8'h00, 8'h00, 14'd0);
        send_item(ACT_PRINT, CH_RETURN, 8'h00, 14'd0);
        send_item(ACT_SET, 8'h00, 8'h00, 14'd3999);
        send_item(ACT_PRINT, 8'h5a, 8'h70, 14'd0);
        send_item(ACT_SET, 8'h00, 8'h00, 14'd4000);
        send_item(ACT_SET, 8'h00, 8'h00, 14'h3fff);
        send_item(ACT_READ, 8'h00, 8'h00, 14'd1999);
        send_item(ACT_READ, 8'h00, 8'h00, 14'd2000);
        send_item(ACT_READ, 8'h00, 8'h00, 14'h3fff);
        send_item(ACT_SET, 8'h00, 8'h00, 14'd3840);
        send_item(ACT_PRINT, CH_NEWLINE, 8'h9c, 14'd0);
        send_item(ACT_READ, 8'h00, 8'h00, 14'd0);
        send_item(ACT_READ, 8'h00, 8'h00, 14'd1999);
        send_item(ACT_CLEAR, 8'h00, 8'h00, 14'd0);
        send_item(ACT_READ, 8'h00, 8'h00, 14'd5);

        // Random phases over several screen sizes, extremes included.
        for (int p = 0; p < 8; p++) begin
            if (p > 0) begin
                write_reg(REG_COLUMNS, col_settings[p]);
                write_reg(REG_ROWS, row_settings[p]);
            end
            for (int n = 0; n < phase_items[p]; n++) send_random();
        end

        i_valid = 1'b0;
        while (console.owed_results.size() != 0) @(negedge i_clk);
        repeat (50) @(posedge i_clk);
        if (console.mismatches == 0) $display("text_console_cell_engine_unit regression: pass");
        else $display("text_console_cell_engine_unit regression: fail");
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl
rtl/tce_pkg.sv
rtl/tce_ram.sv
rtl/text_console_cell_engine_unit.sv
rtl/tce_checker.sv
dv/testbench.sv
